/* src/cfir_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfir_pkg
// Shared constants, types and rounding for the complex FIR filter.
// ----------------------------------------------------------------------------
package cfir_pkg;

  localparam int TapCount  = 16;
  localparam int HistDepth = 15;
  localparam int CoefRegs  = 4;
  localparam int CoefPerReg = 4;
  localparam int CfgIdxW   = $clog2(CoefRegs);
  localparam int CfgDataW  = 64;
  localparam int SampleW   = 16;
  localparam int CoefW     = 16;
  localparam int ProdW     = SampleW + CoefW;
  localparam int GroupSize = 4;
  localparam int NumGroups = (TapCount + GroupSize - 1) / GroupSize;
  localparam int GroupW    = ProdW + 2;
  localparam int AccW      = GroupW + 2;
  localparam int FracShift = 14;

  localparam logic [CfgDataW-1:0] CoefReset0 = 64'd16384;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef sample_t [TapCount-1:0]    window_t;
  typedef coef_t   [TapCount-1:0]    coefs_t;

  function automatic sample_t round_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW:0]           biased;
    logic signed [AccW-FracShift:0] q;
    sample_t                        res;
    biased = (AccW+1)'(acc) + (AccW+1)'(signed'(1 << (FracShift - 1)));
    q      = (AccW-FracShift+1)'(biased >>> FracShift);
    if (q > (AccW-FracShift+1)'(signed'(32767))) begin
      res = 16'sh7fff;
    end else if (q < -(AccW-FracShift+1)'(signed'(32768))) begin
      res = 16'sh8000;
    end else begin
      res = SampleW'(q);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* src/cfir_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cfir_lane
// One real-valued filter lane: registered products, registered group sums,
// then final sum with rounding and saturation into the result register.
// ----------------------------------------------------------------------------
module cfir_lane (
  input  wire                logic clk_i,
  input  wire                logic en_i,
  input  wire cfir_pkg::window_t   win_i,
  input  wire cfir_pkg::coefs_t    coefs_i,
  output cfir_pkg::sample_t  result_o
);
  import cfir_pkg::*;

  logic signed [ProdW-1:0]  prod_q  [TapCount];
  logic signed [GroupW-1:0] group_d [NumGroups];
  logic signed [GroupW-1:0] group_q [NumGroups];
  logic signed [AccW-1:0]   acc;
  sample_t                  result_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < TapCount; k++) begin
        prod_q[k] <= win_i[k] * coefs_i[k];
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      group_d[g] = '0;
      for (int j = 0; j < GroupSize; j++) begin
        if (g * GroupSize + j < TapCount) begin
          group_d[g] = group_d[g] + GroupW'(prod_q[g * GroupSize + j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      group_q <= group_d;
    end
  end

  always_comb begin
    acc = '0;
    for (int g = 0; g < NumGroups; g++) begin
      acc = acc + AccW'(group_q[g]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= round_sat(acc);
    end
  end

  assign result_o = result_q;

endmodule
`default_nettype wire

/* src/complex_fir_filter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// complex_fir_filter
// Pipeline: an accepted input transaction passes through the product, group-sum and result registers.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// result is stalled at the output.
// Reset: delay line cleared, coefficients set to pass-through, no valid data.
// ----------------------------------------------------------------------------
// 16-tap FIR on complex samples with real Q1.14 coefficients, Q2.13 data,
// rounded and saturated output.
// ----------------------------------------------------------------------------
module complex_fir_filter (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [cfir_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  wire logic [cfir_pkg::CfgDataW-1:0]     cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [cfir_pkg::SampleW-1:0] sample_re_i,
  input  wire logic signed [cfir_pkg::SampleW-1:0] sample_im_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [cfir_pkg::SampleW-1:0]    filtered_re_o,
  output logic signed [cfir_pkg::SampleW-1:0]    filtered_im_o
);
  import cfir_pkg::*;

  logic [CfgDataW-1:0] coef_q [CoefRegs];
  sample_t             hist_re_q [HistDepth];
  sample_t             hist_im_q [HistDepth];
  logic                v1_q, v2_q, out_valid_q;
  logic                en, accept;
  window_t             win_re, win_im;
  coefs_t              coefs;
  sample_t             lane_re, lane_im;

  assign en     = !out_valid_q || !out_stall_i;
  assign accept = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= CoefReset0;
      for (int r = 1; r < CoefRegs; r++) begin
        coef_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        hist_re_q[i] <= '0;
        hist_im_q[i] <= '0;
      end
    end else if (accept) begin
      hist_re_q[0] <= sample_re_i;
      hist_im_q[0] <= sample_im_i;
      for (int i = 1; i < HistDepth; i++) begin
        hist_re_q[i] <= hist_re_q[i-1];
        hist_im_q[i] <= hist_im_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_comb begin
    for (int k = 0; k < TapCount; k++) begin
      coefs[k] = coef_q[k / CoefPerReg][(k % CoefPerReg) * CoefW +: CoefW];
      if (k == 0) begin
        win_re[k] = sample_re_i;
        win_im[k] = sample_im_i;
      end else begin
        win_re[k] = hist_re_q[k-1];
        win_im[k] = hist_im_q[k-1];
      end
    end
  end

  cfir_lane u_lane_re (
    .clk_i    (clk_i),
    .en_i     (en),
    .win_i    (win_re),
    .coefs_i  (coefs),
    .result_o (lane_re)
  );

  cfir_lane u_lane_im (
    .clk_i    (clk_i),
    .en_i     (en),
    .win_i    (win_im),
    .coefs_i  (coefs),
    .result_o (lane_im)
  );

  assign in_stall_o    = !en;
  assign out_valid_o   = out_valid_q;
  assign filtered_re_o = lane_re;
  assign filtered_im_o = lane_im;

endmodule
`default_nettype wire
